/* design/tpdq_pkg.sv */
// ----------------------------------------------------------------------------
// tpdq_pkg
// Shared types and codes of the timestamped packet delay queue.
// ----------------------------------------------------------------------------
package tpdq_pkg;

  localparam int TAG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int LAG_W   = 16;
  localparam int FLUSH_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LAG_MS          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INBOUND_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTBOUND_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_COUNT     = 2'd3;

  localparam logic [LAG_W-1:0]   LAG_RESET   = 16'd100;
  localparam logic [FLUSH_W-1:0] FLUSH_RESET = 7'd26;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [1:0] CAUSE_BYPASS  = 2'd0;
  localparam logic [1:0] CAUSE_EXPIRED = 2'd1;
  localparam logic [1:0] CAUSE_FLUSH   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [TAG_W-1:0]  packet_tag;
    logic              is_outbound;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic [1:0]       cause;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic bypass;
    logic tick_load;
    logic pop_expire;
    logic finish_expire;
    logic load_todo;
    logic pop_flush;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    logic full;
    logic expire_ok;
    logic todo_zero;
    logic todo_one;
  } dp_status_t;

endpackage

/* design/timestamped_packet_delay_queue_top.sv */
// ----------------------------------------------------------------------------
// timestamped_packet_delay_queue_top
// A packet item does not raise busy; a bypass result is valid in the cycle after the accept.
// A tick item that releases n expired entries raises busy; its results come one per cycle,
// and when no flush follows, the last is valid in the same cycle that busy falls.
// A tick that forces out f entries holds busy while it does so, and each flush result is
// valid in the cycle after its pop. The receiver cannot stall.
// Reset is asynchronous: pointers, fill count, configuration registers and flags return to defaults.
// ----------------------------------------------------------------------------
module timestamped_packet_delay_queue_top #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  tpdq_pkg::in_item_t               in_i,
  output logic                             result_valid_o,
  output tpdq_pkg::out_item_t              result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tpdq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpdq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tpdq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tpdq_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (in_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  tpdq_datapath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* design/tpdq_datapath.sv */
// ----------------------------------------------------------------------------
// tpdq_datapath
// Storage, pointers, fill count, configuration registers and result register.
// ----------------------------------------------------------------------------
module tpdq_datapath #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpdq_pkg::in_item_t               in_i,
  input  tpdq_pkg::dp_cmd_t                cmd_i,
  output tpdq_pkg::dp_status_t             status_o,
  input  logic                             cfg_we_i,
  input  logic [tpdq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpdq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             result_valid_o,
  output tpdq_pkg::out_item_t              result_o
);
  import tpdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = (CW > FLUSH_W) ? CW : FLUSH_W;
  localparam int TB = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [TB-1:0]     tag_mem [DEPTH];
  logic [TIME_W-1:0] stamp_mem [DEPTH];

  logic [AW-1:0]     rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [TW-1:0]     todo_q, todo_d;
  logic [TB-1:0]     head_tag_q, pend_tag_q;
  logic [TIME_W-1:0] head_stamp_q, now_q, age;
  logic              pend_valid_q;
  logic [LAG_W-1:0]  lag_q;
  logic              in_en_q, out_en_q;
  logic [FLUSH_W-1:0] flush_q;
  logic [TW-1:0]     fill_ext, flush_ext;
  logic              res_valid_q;
  out_item_t         res_q;

  assign fill_ext  = TW'(fill_q);
  assign flush_ext = TW'(flush_q);
  assign age       = now_q - head_stamp_q;

  assign status_o.enabled   = in_i.is_outbound ? out_en_q : in_en_q;
  assign status_o.full      = (fill_q == CW'(DEPTH));
  assign status_o.expire_ok = (fill_q != '0) && (age > TIME_W'(lag_q));
  assign status_o.todo_zero = (todo_q == '0);
  assign status_o.todo_one  = (todo_q == TW'(1));

  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    fill_d = fill_q;
    todo_d = todo_q;
    if (cmd_i.push) begin
      wptr_d = (wptr_q == LAST_IDX) ? '0 : wptr_q + AW'(1);
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.pop_expire || cmd_i.pop_flush) begin
      rptr_d = (rptr_q == LAST_IDX) ? '0 : rptr_q + AW'(1);
      fill_d = fill_q - CW'(1);
    end
    if (cmd_i.load_todo) begin
      todo_d = (flush_ext < fill_ext) ? flush_ext : fill_ext;
    end else if (cmd_i.pop_flush) begin
      todo_d = todo_q - TW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      tag_mem[wptr_q]   <= in_i.packet_tag[TB-1:0];
      stamp_mem[wptr_q] <= in_i.now_ms;
    end
    if (cmd_i.push && (wptr_q == rptr_d)) begin
      head_tag_q   <= in_i.packet_tag[TB-1:0];
      head_stamp_q <= in_i.now_ms;
    end else begin
      head_tag_q   <= tag_mem[rptr_d];
      head_stamp_q <= stamp_mem[rptr_d];
    end
    if (cmd_i.tick_load) begin
      now_q <= in_i.now_ms;
    end
    if (cmd_i.pop_expire) begin
      pend_tag_q <= head_tag_q;
    end
    if (cmd_i.bypass) begin
      res_q <= '{out_tag: TAG_W'(in_i.packet_tag[TB-1:0]), cause: CAUSE_BYPASS,
                 last: 1'b1};
    end else if (cmd_i.pop_expire) begin
      res_q <= '{out_tag: TAG_W'(pend_tag_q), cause: CAUSE_EXPIRED, last: 1'b0};
    end else if (cmd_i.finish_expire) begin
      res_q <= '{out_tag: TAG_W'(pend_tag_q), cause: CAUSE_EXPIRED, last: 1'b1};
    end else if (cmd_i.pop_flush) begin
      res_q <= '{out_tag: TAG_W'(head_tag_q), cause: CAUSE_FLUSH,
                 last: status_o.todo_one};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q       <= '0;
      wptr_q       <= '0;
      fill_q       <= '0;
      todo_q       <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      lag_q        <= LAG_RESET;
      in_en_q      <= 1'b1;
      out_en_q     <= 1'b1;
      flush_q      <= FLUSH_RESET;
    end else begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      fill_q <= fill_d;
      todo_q <= todo_d;
      res_valid_q <= cmd_i.bypass || cmd_i.pop_flush ||
                     ((cmd_i.pop_expire || cmd_i.finish_expire) && pend_valid_q);
      if (cmd_i.pop_expire) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish_expire) begin
        pend_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LAG_MS:          lag_q    <= cfg_data_i;
          CFG_INBOUND_ENABLE:  in_en_q  <= cfg_data_i[0];
          CFG_OUTBOUND_ENABLE: out_en_q <= cfg_data_i[0];
          CFG_FLUSH_COUNT:     flush_q  <= cfg_data_i[FLUSH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* design/tpdq_controller.sv */
// ----------------------------------------------------------------------------
// tpdq_controller
// Sequences packet items and the release and flush walks of a tick.
// ----------------------------------------------------------------------------
module tpdq_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  kind_i,
  input  tpdq_pkg::dp_status_t  status_i,
  output tpdq_pkg::dp_cmd_t     cmd_o,
  output logic                  busy_o
);
  import tpdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_TICK) begin
            cmd_o.tick_load = 1'b1;
            state_d = ST_EXPIRE;
          end else if (status_i.enabled && !status_i.full) begin
            cmd_o.push = 1'b1;
          end else begin
            cmd_o.bypass = 1'b1;
          end
        end
      end
      ST_EXPIRE: begin
        if (status_i.expire_ok) begin
          cmd_o.pop_expire = 1'b1;
        end else if (status_i.full) begin
          cmd_o.load_todo = 1'b1;
          state_d = ST_FLUSH;
        end else begin
          cmd_o.finish_expire = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.todo_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.pop_flush = 1'b1;
          if (status_i.todo_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule
